>>> hdl/aes128_block_cipher_defines.svh
// assertion macros shared by the checker
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define AES128_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aes128 check failed");

// next-cycle implication
`define AES128_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aes128 check failed");

`endif

>>> hdl/aes128_pkg.sv
package aes128_pkg;

  localparam int unsigned Rounds  = 10;
  localparam int unsigned RndW    = $clog2(Rounds + 1);
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic            key_load;
    logic            key_step;
    logic [RndW-1:0] key_idx;
    logic            blk_load;
    logic            round_en;
    logic            round_last;
    logic [RndW-1:0] round_num;
  } ctrl_cmd_t;

  typedef logic [255:0][7:0] sbox_t;

  localparam logic [7:0] RCON [Rounds+1] = '{
    8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // byte i sits at row (i % 4), column (i / 4); fwd shift takes s[i] from s[map[i]]
  localparam logic [3:0] SHIFT_MAP [16] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
  };

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // used only while building the tables
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] x);
    logic [7:0] sq;
    logic [7:0] r;
    sq = x;
    r  = 8'h01;
    for (int k = 1; k < 8; k++) begin
      sq = gf_mul(sq, sq);
      r  = gf_mul(r, sq);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] v, int unsigned n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic sbox_t gen_sbox();
    sbox_t      t;
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = gf_inv(x[7:0]);
      t[x] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    end
    return t;
  endfunction

  function automatic sbox_t gen_inv_sbox();
    sbox_t      t;
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      b = rotl8(x[7:0], 1) ^ rotl8(x[7:0], 3) ^ rotl8(x[7:0], 6) ^ 8'h05;
      t[x] = gf_inv(b);
    end
    return t;
  endfunction

  localparam sbox_t SBOX     = gen_sbox();
  localparam sbox_t INV_SBOX = gen_inv_sbox();

  function automatic logic [7:0] get_byte(logic [127:0] s, int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_fwd(logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = SBOX[get_byte(s, i)];
    return r;
  endfunction

  function automatic logic [127:0] sub_inv(logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = INV_SBOX[get_byte(s, i)];
    return r;
  endfunction

  function automatic logic [127:0] shift_fwd(logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = get_byte(s, SHIFT_MAP[i]);
    return r;
  endfunction

  function automatic logic [127:0] shift_back(logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[127-8*SHIFT_MAP[i] -: 8] = get_byte(s, i);
    return r;
  endfunction

  function automatic logic [31:0] mix_col(logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // multiples 9, 11, 13, 14 of one byte, built from doublings
  function automatic logic [31:0] mul_set(logic [7:0] a);
    logic [7:0] m2, m4, m8;
    m2 = xtime(a);
    m4 = xtime(m2);
    m8 = xtime(m4);
    return {m8 ^ a, m8 ^ m2 ^ a, m8 ^ m4 ^ a, m8 ^ m4 ^ m2};
  endfunction

  function automatic logic [31:0] inv_mix_col(logic [31:0] c);
    logic [31:0] p0, p1, p2, p3;
    // fields: [31:24] x9, [23:16] x11, [15:8] x13, [7:0] x14
    p0 = mul_set(c[31:24]);
    p1 = mul_set(c[23:16]);
    p2 = mul_set(c[15:8]);
    p3 = mul_set(c[7:0]);
    return {p0[7:0] ^ p1[23:16] ^ p2[15:8] ^ p3[31:24],
            p0[31:24] ^ p1[7:0] ^ p2[23:16] ^ p3[15:8],
            p0[15:8] ^ p1[31:24] ^ p2[7:0] ^ p3[23:16],
            p0[23:16] ^ p1[15:8] ^ p2[31:24] ^ p3[7:0]};
  endfunction

  function automatic logic [127:0] mix_fwd(logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) r[127-32*c -: 32] = mix_col(s[127-32*c -: 32]);
    return r;
  endfunction

  function automatic logic [127:0] mix_back(logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) r[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
    return r;
  endfunction

  // one step of the key schedule
  function automatic logic [127:0] key_next(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

>>> hdl/aes128_block_cipher.sv
// aes-128 encrypt/decrypt, one round per cycle on a shared round unit
// a block is taken only while busy is low, so a new block waits until the previous result is out
// round keys are expanded after reset and after each key write (busy high)
// reset: async active low; keys reset to zero and the zero-key schedule is built
// results are shown for one cycle only; the receiver cannot stall
module aes128_block_cipher import aes128_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_item_t           data_i,
  output logic               result_valid_o,
  output out_item_t          result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  ctrl_cmd_t cmd;
  logic      cfg_wr;
  logic      key_wr;
  logic      start_acc;

  // config beat always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign key_wr      = cfg_wr && (cfg_index_i == REG_KEY_HIGH || cfg_index_i == REG_KEY_LOW);
  assign start_acc   = start && !busy;

  aes128_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_acc),
    .key_wr_i (key_wr),
    .busy_o   (busy),
    .done_o   (result_valid_o),
    .cmd_o    (cmd)
  );

  aes128_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .data_i      (data_i),
    .cmd_i       (cmd),
    .result_o    (result_o)
  );

endmodule

>>> hdl/aes128_ctrl.sv
module aes128_ctrl import aes128_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      key_wr_i,
  output logic      busy_o,
  output logic      done_o,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e          state_q;
  logic [RndW-1:0] cnt_q;
  logic            rekey_q;
  logic            busy_q;
  logic            done_q;

  localparam logic [RndW-1:0] LastRnd = RndW'(Rounds);

  // command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.key_idx    = cnt_q;
    cmd_o.round_num  = cnt_q;
    cmd_o.round_last = (cnt_q == LastRnd);
    case (state_q)
      ST_EXPAND: begin
        cmd_o.key_load = (cnt_q == '0);
        cmd_o.key_step = (cnt_q != '0);
      end
      ST_IDLE:   cmd_o.blk_load = start_i;
      ST_RUN:    cmd_o.round_en = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  // state, round counter and registered status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EXPAND;
      cnt_q   <= '0;
      rekey_q <= 1'b0;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_EXPAND: begin
          if (key_wr_i) begin
            cnt_q <= '0;
          end else if (cnt_q == LastRnd) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_RUN;
            cnt_q   <= RndW'(1);
            busy_q  <= 1'b1;
            rekey_q <= key_wr_i;
          end else if (key_wr_i) begin
            state_q <= ST_EXPAND;
            cnt_q   <= '0;
            busy_q  <= 1'b1;
          end
        end
        ST_RUN: begin
          if (cnt_q == LastRnd) begin
            done_q <= 1'b1;
            cnt_q  <= '0;
            if (rekey_q || key_wr_i) begin
              state_q <= ST_EXPAND;
              rekey_q <= 1'b0;
            end else begin
              state_q <= ST_IDLE;
              busy_q  <= 1'b0;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
            if (key_wr_i) rekey_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_EXPAND;
          cnt_q   <= '0;
          busy_q  <= 1'b1;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

>>> hdl/aes128_dp.sv
module aes128_dp import aes128_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  in_item_t           data_i,
  input  ctrl_cmd_t          cmd_i,
  output out_item_t          result_o
);

  logic [63:0]     key_hi_q, key_lo_q;
  logic [127:0]    kw_q, kw_d;
  logic [127:0]    rk_mem [Rounds+1];
  logic [127:0]    state_q;
  logic            kind_q;
  logic [RndW-1:0] rd_idx;
  logic [127:0]    rk;
  logic [127:0]    enc_d, dec_d;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_wr_i) begin
      if (cfg_index_i == REG_KEY_HIGH) key_hi_q <= cfg_data_i;
      if (cfg_index_i == REG_KEY_LOW)  key_lo_q <= cfg_data_i;
    end
  end

  // key expansion, one round key per cycle
  assign kw_d = cmd_i.key_load ? {key_hi_q, key_lo_q} : key_next(kw_q, RCON[cmd_i.key_idx]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load || cmd_i.key_step) begin
      kw_q                  <= kw_d;
      rk_mem[cmd_i.key_idx] <= kw_d;
    end
  end

  // round key select: encrypt walks up, decrypt walks down
  always_comb begin
    if (cmd_i.blk_load) rd_idx = data_i.kind ? RndW'(Rounds) : '0;
    else                rd_idx = kind_q ? RndW'(Rounds) - cmd_i.round_num : cmd_i.round_num;
  end
  assign rk = rk_mem[rd_idx];

  // one round in each direction
  always_comb begin
    logic [127:0] e, d;
    e = shift_fwd(sub_fwd(state_q));
    if (!cmd_i.round_last) e = mix_fwd(e);
    enc_d = e ^ rk;
    d = sub_inv(shift_back(state_q)) ^ rk;
    if (!cmd_i.round_last) d = mix_back(d);
    dec_d = d;
  end

  // state register, also the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_load) begin
      state_q <= {data_i.block_high, data_i.block_low} ^ rk;
      kind_q  <= data_i.kind;
    end else if (cmd_i.round_en) begin
      state_q <= kind_q ? dec_d : enc_d;
    end
  end

  assign result_o.result_high = state_q[127:64];
  assign result_o.result_low  = state_q[63:0];

endmodule

>>> hdl/aes128_chk.sv
`include "aes128_block_cipher_defines.svh"

module aes128_chk import aes128_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // a taken block makes the core busy
  `AES128_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  // every taken block is followed by its result beat
  `AES128_ASSERT_NOW(a_result_latency, start && !busy, ##11 result_valid_o)
  // result beat lasts one cycle
  `AES128_ASSERT_NEXT(a_valid_pulse, result_valid_o, !result_valid_o)
  // a result only follows a busy period
  `AES128_ASSERT_NOW(a_valid_after_busy, result_valid_o, $past(busy))

endmodule

bind aes128_block_cipher aes128_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);
